FILE: hdl/binary32_multiplier_assert.svh
// Assertion macros for the binary32 multiplier.
// Included by the top level; needs clock and reset in scope.
`ifndef BINARY32_MULTIPLIER_ASSERT_SVH
`define BINARY32_MULTIPLIER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define B32M_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define B32M_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/b32m_pkg.sv
// Package for the binary32 multiplier: widths, constants and the
// classify-to-execute record. No dependencies.
package b32m_pkg;

   localparam int ExpBias   = 127;
   localparam int FracBits  = 23;
   localparam int SigBits   = 24;
   localparam int QueueDepth = 2;

   // Classified operand pair handed from the front end to the back end.
   typedef struct packed {
      logic                 sign;
      logic                 bad_operand;
      logic [9:0]           exp_sum;     // ea + eb, unbiased later
      logic [SigBits-1:0]   sig_a;
      logic [SigBits-1:0]   sig_b;
   } op_rec_type;

   // One result item.
   typedef struct packed {
      logic        unsupported;
      logic        overflow;
      logic [31:0] product;
   } result_type;

endpackage

FILE: hdl/b32m_front.sv
// Front end: accepts operand pairs, splits and classifies them.
// Depends on b32m_pkg.
module b32m_front import b32m_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] operand_a,
   input  logic [31:0] operand_b,
   output logic        rec_valid,
   input  logic        rec_ready,
   output op_rec_type  rec
);
   logic       valid_ff;
   op_rec_type rec_ff, rec_in;
   logic [7:0] ea, eb;

   assign ea = operand_a[30:23];
   assign eb = operand_b[30:23];

   // Classification of the operand pair.
   always_comb begin
      rec_in.sign        = operand_a[31] ^ operand_b[31];
      rec_in.bad_operand = (ea == 8'd0) || (ea == 8'hFF) || (eb == 8'd0) || (eb == 8'hFF);
      rec_in.exp_sum     = {2'b00, ea} + {2'b00, eb};
      rec_in.sig_a       = {1'b1, operand_a[22:0]};
      rec_in.sig_b       = {1'b1, operand_b[22:0]};
   end

   assign in_ready  = !valid_ff || rec_ready;
   assign rec_valid = valid_ff;
   assign rec       = rec_ff;

   // Output register toward the queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rec_ff <= rec_in;
      end
   end
endmodule

FILE: hdl/b32m_queue.sv
// Two-entry queue between front and back end.
// Depends on b32m_pkg.
module b32m_queue import b32m_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_valid,
   output logic       wr_ready,
   input  op_rec_type wr_data,
   output logic       rd_valid,
   input  logic       rd_ready,
   output op_rec_type rd_data
);
   op_rec_type mem_ff [QueueDepth];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       do_wr, do_rd;

   assign wr_ready = (count_ff != 2'(QueueDepth));
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = mem_ff[rptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_wr) wptr_ff <= ~wptr_ff;
         if (do_rd) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + {1'b0, do_wr} - {1'b0, do_rd};
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end
endmodule

FILE: hdl/b32m_back.sv
// Back end: two stages, a significand multiply, then normalize, round and pack.
// Depends on b32m_pkg.
module b32m_back import b32m_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       rec_valid,
   output logic       rec_ready,
   input  op_rec_type rec,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res
);
   // Stage 1 registers: raw product.
   logic        s1_valid_ff;
   logic        s1_sign_ff, s1_bad_ff;
   logic [9:0]  s1_exp_ff;
   logic [47:0] s1_prod_ff;
   // Stage 2 registers: result.
   logic        s2_valid_ff;
   result_type  s2_res_ff, s2_res_in;
   logic        adv2, adv1;

   assign adv2      = !s2_valid_ff || res_ready;
   assign adv1      = !s1_valid_ff || adv2;
   assign rec_ready = adv1;
   assign res_valid = s2_valid_ff;
   assign res       = s2_res_ff;

   // Stage 1: significand multiply.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= rec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && rec_valid) begin
         s1_sign_ff <= rec.sign;
         s1_bad_ff  <= rec.bad_operand;
         s1_exp_ff  <= rec.exp_sum;
         s1_prod_ff <= {24'd0, rec.sig_a} * {24'd0, rec.sig_b};
      end
   end

   // Stage 2 logic: normalize, round to nearest even, range checks.
   logic        top;
   logic [23:0] keep;
   logic        guard, sticky;
   logic [24:0] rounded;
   logic [10:0] bexp;   // ea + eb after normalization and rounding; one bias still to remove
   logic [10:0] bexp0;  // ea + eb after normalization; one bias still to remove
   always_comb begin
      top    = s1_prod_ff[47];
      keep   = top ? s1_prod_ff[47:24] : s1_prod_ff[46:23];
      guard  = top ? s1_prod_ff[23] : s1_prod_ff[22];
      sticky = top ? (|s1_prod_ff[22:0]) : (|s1_prod_ff[21:0]);
      rounded = {1'b0, keep} + {24'd0, guard && (sticky || keep[0])};
      // ea + eb + top; the bias of 127 is taken off at packing, after the range checks
      bexp0 = {1'b0, s1_exp_ff} + {10'd0, top};
      bexp  = bexp0 + {10'd0, rounded[24]};
      s2_res_in = '0;
      if (s1_bad_ff || bexp0 < 11'(ExpBias + 1)) begin
         s2_res_in.unsupported = 1'b1;
      end else if (bexp >= 11'(ExpBias + 255)) begin
         s2_res_in.overflow = 1'b1;
         s2_res_in.product  = {s1_sign_ff, 8'hFF, 23'd0};
      end else begin
         s2_res_in.product = {s1_sign_ff, 8'(bexp - 11'(ExpBias)),
                              rounded[24] ? rounded[23:1] : rounded[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         s2_res_ff <= s2_res_in;
      end
   end
endmodule

FILE: hdl/binary32_multiplier.sv
// Channel  | Port group          | Payload (lowest bit up)
// request  | req_tvalid/tready   | tdata: operand_a[31:0], operand_b[63:32]
// response | rsp_tvalid/tready   | tdata: product[31:0], overflow[32], unsupported[33], pad
//
// One operand pair per cycle sustained while the response side keeps up; a request
// passes the front register, queue, multiply stage and round stage to the response.
// The 24x24 significand multiply sets the stage timing.
// Synchronous active-high reset clears all valid state; there are no settings.
// Either side may stall; the queue lets the front keep accepting briefly.
//
// Top level of the binary32 multiplier; instantiates front, queue and back.
// Depends on b32m_pkg and binary32_multiplier_assert.svh.
`include "binary32_multiplier_assert.svh"
module binary32_multiplier import b32m_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // operand_a, operand_b
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // product, overflow, unsupported, zero pad
);
   logic       f_valid, f_ready, q_valid, q_ready;
   op_rec_type f_rec, q_rec;
   result_type res;

   b32m_front u_front (
      .clock, .reset,
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .operand_a (req_tdata[31:0]),
      .operand_b (req_tdata[63:32]),
      .rec_valid (f_valid),
      .rec_ready (f_ready),
      .rec       (f_rec)
   );

   b32m_queue u_queue (
      .clock, .reset,
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  (f_rec),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_rec)
   );

   b32m_back u_back (
      .clock, .reset,
      .rec_valid (q_valid),
      .rec_ready (q_ready),
      .rec       (q_rec),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res       (res)
   );

   assign rsp_tdata = {6'd0, res.unsupported, res.overflow, res.product};

   // Sanity checks on the result encoding and on flow through the queue.
   `B32M_ASSERT_IMPL(a_flags_excl, rsp_tvalid, !(res.overflow && res.unsupported), "both flags")
   `B32M_ASSERT_IMPL(a_unsup_zero, rsp_tvalid && res.unsupported, res.product == 32'd0, "nonzero")
   `B32M_ASSERT_IMPL(a_ovf_inf, rsp_tvalid && res.overflow, res.product[30:0] == 31'h7F800000, "inf")
   `B32M_ASSERT_NEXT(a_queue_hold, q_valid && !q_ready, q_valid, "queue lost an entry under stall")
endmodule
